// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// assertion sampled on clk, disabled while rst_n is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// assertion sampled on clk, also checked during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/core/arenv_pkg.sv =====
// ----------------------------------------------------------------------------
// arenv_pkg
// Types, constants and codes shared by the envelope amplifier modules.
// ----------------------------------------------------------------------------
package arenv_pkg;

    // field widths
    localparam int SAMPLE_BITS     = 16;
    localparam int LEVEL_FRAC_BITS = 16;
    localparam int LEVEL_BITS      = LEVEL_FRAC_BITS + 1;
    localparam int STEP_BITS       = LEVEL_BITS;
    localparam int GAIN_BITS       = 16;
    localparam int GAIN_FRAC_BITS  = 12;
    localparam int PHASE_BITS      = 2;

    // configuration port
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = (STEP_BITS > GAIN_BITS) ? STEP_BITS : GAIN_BITS;

    // shared multiplier: A is the sample or the sample*gain product, B is gain or level
    localparam int MUL_A_W     = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int MUL_B_W     = ((LEVEL_BITS > GAIN_BITS) ? LEVEL_BITS : GAIN_BITS) + 1;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int SCALE_SHIFT = GAIN_FRAC_BITS + LEVEL_FRAC_BITS;

    // level constants
    localparam logic [LEVEL_BITS-1:0] LEVEL_ONE  = LEVEL_BITS'(1) << LEVEL_FRAC_BITS;
    localparam logic [LEVEL_BITS-1:0] LEVEL_ZERO = '0;

    // register reset values
    localparam logic [STEP_BITS-1:0] ATTACK_STEP_RST  = STEP_BITS'(64);
    localparam logic [STEP_BITS-1:0] RELEASE_STEP_RST = STEP_BITS'(64);
    localparam logic [GAIN_BITS-1:0] GAIN_RST         = GAIN_BITS'(1) << GAIN_FRAC_BITS;

    // register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ATTACK_STEP  = 4'd0,
        CFG_RELEASE_STEP = 4'd1,
        CFG_GAIN_LEFT    = 4'd2,
        CFG_GAIN_RIGHT   = 4'd3
    } t_cfg_idx;

    // envelope phase codes
    typedef enum logic [PHASE_BITS-1:0] {
        PH_OFF     = 2'd0,
        PH_ATTACK  = 2'd1,
        PH_HOLD    = 2'd2,
        PH_RELEASE = 2'd3
    } t_env_phase;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_L_GAIN,
        ST_MUL_L_LEVEL,
        ST_MUL_R_GAIN,
        ST_MUL_R_LEVEL,
        ST_STALL
    } t_ctrl_state;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MS_L_GAIN,
        MS_L_LEVEL,
        MS_R_GAIN,
        MS_R_LEVEL
    } t_mul_sel;

    // payloads
    typedef struct packed {
        logic                          gate;
        logic signed [SAMPLE_BITS-1:0] sample_left;
        logic signed [SAMPLE_BITS-1:0] sample_right;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] result_left;
        logic signed [SAMPLE_BITS-1:0] result_right;
        logic        [LEVEL_BITS-1:0]  level_now;
        logic        [PHASE_BITS-1:0]  phase_now;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     env_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     push_direct;
        logic     save_right;
        logic     push_staged;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/core/arenv_ctrl.sv =====
// ----------------------------------------------------------------------------
// arenv_ctrl
// Sequencer: steps one item through the four passes of the shared multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arenv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  arenv_pkg::t_dp_sts i_sts,
    output arenv_pkg::t_dp_cmd o_cmd
);
    import arenv_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        w_ready;

    // ready when idle, or when the last pass or the stall state can hand its result on
    always_comb begin
        unique case (r_state)
            ST_IDLE:        w_ready = 1'b1;
            ST_MUL_R_LEVEL: w_ready = i_sts.out_free;
            ST_STALL:       w_ready = i_sts.out_free;
            default:        w_ready = 1'b0;
        endcase
    end

    assign o_in_ready = w_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_MUL_L_GAIN;
            end
            ST_MUL_L_GAIN:  n_state = ST_MUL_L_LEVEL;
            ST_MUL_L_LEVEL: n_state = ST_MUL_R_GAIN;
            ST_MUL_R_GAIN:  n_state = ST_MUL_R_LEVEL;
            ST_MUL_R_LEVEL: begin
                if (!i_sts.out_free) n_state = ST_STALL;
                else if (i_in_valid) n_state = ST_MUL_L_GAIN;
                else                 n_state = ST_IDLE;
            end
            ST_STALL: begin
                if (i_sts.out_free) begin
                    n_state = i_in_valid ? ST_MUL_L_GAIN : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MS_L_GAIN;
        o_cmd.load_in = i_in_valid && w_ready;
        unique case (r_state)
            ST_IDLE: ;
            ST_MUL_L_GAIN: begin
                o_cmd.env_step = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MS_L_GAIN;
            end
            ST_MUL_L_LEVEL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_L_LEVEL;
            end
            ST_MUL_R_GAIN: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_R_GAIN;
            end
            ST_MUL_R_LEVEL: begin
                o_cmd.mul_en      = 1'b1;
                o_cmd.mul_sel     = MS_R_LEVEL;
                o_cmd.push_direct = i_sts.out_free;
                o_cmd.save_right  = !i_sts.out_free;
            end
            ST_STALL: begin
                o_cmd.push_staged = i_sts.out_free;
            end
            default: ;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // checks
    `ASSERT_CLK(a_pass_order, i_clk, i_rst_n, (r_state == ST_MUL_L_GAIN) |=> (r_state == ST_MUL_L_LEVEL))
    `ASSERT_CLK(a_push_free, i_clk, i_rst_n, (o_cmd.push_direct || o_cmd.push_staged) |-> i_sts.out_free)
    `ASSERT_CLK(a_one_result_action, i_clk, i_rst_n, $onehot0({o_cmd.push_direct, o_cmd.save_right, o_cmd.push_staged}))
    `ASSERT_CLK(a_stall_from_busy, i_clk, i_rst_n, $rose(r_state == ST_STALL) |-> $past(!i_sts.out_free))

endmodule

// ===== rtl/core/arenv_datapath.sv =====
// ----------------------------------------------------------------------------
// arenv_datapath
// Registers, envelope step, shared multiplier, saturation and output register.
// ----------------------------------------------------------------------------
module arenv_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  arenv_pkg::t_in_item                   i_in_data,
    input  logic                                  i_cfg_valid,
    input  logic [arenv_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [arenv_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output arenv_pkg::t_out_item                  o_out_data,
    input  arenv_pkg::t_dp_cmd                    i_cmd,
    output arenv_pkg::t_dp_sts                    o_sts
);
    import arenv_pkg::*;

    // configuration registers
    logic [STEP_BITS-1:0] r_attack_step;
    logic [STEP_BITS-1:0] r_release_step;
    logic [GAIN_BITS-1:0] r_gain_left;
    logic [GAIN_BITS-1:0] r_gain_right;

    // envelope state
    t_env_phase           r_phase;
    t_env_phase           n_phase;
    logic [LEVEL_BITS-1:0] r_level;
    logic [LEVEL_BITS-1:0] n_level;
    logic [LEVEL_BITS:0]   w_sum;
    logic [LEVEL_BITS:0]   w_diff;

    // work registers
    t_in_item                      r_in;
    logic signed [MUL_A_W-1:0]     r_p1;
    logic signed [SAMPLE_BITS-1:0] r_res_l;
    logic signed [SAMPLE_BITS-1:0] r_res_r;
    t_out_item                     r_out;
    logic                          r_out_valid;

    // multiplier and saturation
    logic signed [MUL_A_W-1:0]         w_mul_a;
    logic signed [MUL_B_W-1:0]         w_mul_b;
    logic signed [MUL_P_W-1:0]         w_prod;
    logic signed [MUL_P_W-1:0]         w_shifted;
    logic [MUL_P_W-SAMPLE_BITS:0]      w_upper;
    logic signed [SAMPLE_BITS-1:0]     w_sat;

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_step  <= ATTACK_STEP_RST;
            r_release_step <= RELEASE_STEP_RST;
            r_gain_left    <= GAIN_RST;
            r_gain_right   <= GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATTACK_STEP:  r_attack_step  <= i_cfg_data[STEP_BITS-1:0];
                CFG_RELEASE_STEP: r_release_step <= i_cfg_data[STEP_BITS-1:0];
                CFG_GAIN_LEFT:    r_gain_left    <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_RIGHT:   r_gain_right   <= i_cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // envelope step: clamp only when the sum overshoots 1.0 or drops below 0
    assign w_sum  = {1'b0, r_level} + {1'b0, r_attack_step};
    assign w_diff = {1'b0, r_level} - {1'b0, r_release_step};

    always_comb begin
        n_phase = r_phase;
        n_level = r_level;
        unique case (r_phase)
            PH_OFF: begin
                if (r_in.gate) n_phase = PH_ATTACK;
            end
            PH_ATTACK: begin
                if (w_sum > {1'b0, LEVEL_ONE}) begin
                    n_level = LEVEL_ONE;
                    n_phase = PH_HOLD;
                end else begin
                    n_level = w_sum[LEVEL_BITS-1:0];
                end
            end
            PH_HOLD: begin
                if (!r_in.gate) n_phase = PH_RELEASE;
            end
            PH_RELEASE: begin
                if (w_diff[LEVEL_BITS]) begin
                    n_level = LEVEL_ZERO;
                    n_phase = PH_OFF;
                end else begin
                    n_level = w_diff[LEVEL_BITS-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OFF;
            r_level <= LEVEL_ZERO;
        end else if (i_cmd.env_step) begin
            r_phase <= n_phase;
            r_level <= n_level;
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        unique case (i_cmd.mul_sel) inside
            MS_L_GAIN: begin
                w_mul_a = MUL_A_W'(r_in.sample_left);
                w_mul_b = signed'(MUL_B_W'(r_gain_left));
            end
            MS_R_GAIN: begin
                w_mul_a = MUL_A_W'(r_in.sample_right);
                w_mul_b = signed'(MUL_B_W'(r_gain_right));
            end
            MS_L_LEVEL, MS_R_LEVEL: begin
                w_mul_a = r_p1;
                w_mul_b = signed'(MUL_B_W'(r_level));
            end
            default: begin
                w_mul_a = r_p1;
                w_mul_b = signed'(MUL_B_W'(r_level));
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // floor shift, then saturate to the sample range
    assign w_shifted = w_prod >>> SCALE_SHIFT;
    assign w_upper   = w_shifted[MUL_P_W-1:SAMPLE_BITS-1];

    always_comb begin
        if ((&w_upper) || !(|w_upper)) begin
            w_sat = w_shifted[SAMPLE_BITS-1:0];
        end else if (w_shifted[MUL_P_W-1]) begin
            w_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_data;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel) inside
                MS_L_GAIN, MS_R_GAIN: r_p1    <= w_prod[MUL_A_W-1:0];
                MS_L_LEVEL:           r_res_l <= w_sat;
                default: ;
            endcase
        end
        if (i_cmd.save_right) begin
            r_res_r <= w_sat;
        end
        if (i_cmd.push_direct) begin
            r_out.result_left  <= r_res_l;
            r_out.result_right <= w_sat;
            r_out.level_now    <= r_level;
            r_out.phase_now    <= r_phase;
        end else if (i_cmd.push_staged) begin
            r_out.result_left  <= r_res_l;
            r_out.result_right <= r_res_r;
            r_out.level_now    <= r_level;
            r_out.phase_now    <= r_phase;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_direct || i_cmd.push_staged) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/attack_release_envelope_amp_core.sv =====
// ----------------------------------------------------------------------------
// attack_release_envelope_amp_core
// Stereo linear attack/release envelope amplifier, top level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one request:
//   a gate bit and a signed stereo sample pair. Output channel (o_out_valid /
//   i_out_ready / o_out_data) returns exactly one result per request: both
//   scaled samples, the envelope level and phase after the step.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data)
//   writes attack step, release step, left gain, right gain (index 0..3);
//   other indexes are ignored. Write it only while the block is idle.
//   Sequence: after a request is accepted, the single shared multiplier does
//   sample*gain and then *level for each channel in turn (passes L_GAIN,
//   L_LEVEL, R_GAIN, R_LEVEL); the last pass writes the output register.
//   A new request is accepted in the last multiplier pass, so the next
//   request overlaps the last pass while the output drains.
//   Stall: if the output register is still full at the last pass, the right
//   result is parked and the block waits; input is held off until the
//   output register frees up.
//   Reset (i_rst_n low, synchronous): envelope off at level 0, registers to
//   their defaults, no output pending.
// ----------------------------------------------------------------------------
module attack_release_envelope_amp_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  arenv_pkg::t_in_item                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output arenv_pkg::t_out_item                o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [arenv_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [arenv_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import arenv_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    arenv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    arenv_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

// ===== sim/arenv_amp_checker.sv =====
// ----------------------------------------------------------------------------
// arenv_amp_checker
// Watches the request, result and register channels of the envelope
// amplifier, predicts each result from its own copy of the envelope state
// and registers, and compares every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arenv_amp_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  arenv_pkg::t_in_item                 i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  arenv_pkg::t_out_item                i_out_data,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [arenv_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [arenv_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_outstanding
);
    import arenv_pkg::*;

    localparam int MAX_PRINTED = 40;

    // predicted envelope state and register copies
    t_env_phase            env_phase;
    logic [LEVEL_BITS-1:0] env_level;
    logic [STEP_BITS-1:0]  attack_step;
    logic [STEP_BITS-1:0]  release_step;
    logic [GAIN_BITS-1:0]  gain_left;
    logic [GAIN_BITS-1:0]  gain_right;

    t_out_item expected_results[$];
    int        mismatch_count = 0;
    int        pending_results = 0;

    assign o_fail_count  = mismatch_count;
    assign o_outstanding = pending_results;

    // one line per mismatch, printing capped to keep the log short
    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (mismatch_count < MAX_PRINTED) begin
            $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        end
        mismatch_count++;
    endtask

    // sample * gain * level, floor-shifted by the gain and level fractions, saturated
    function automatic logic signed [SAMPLE_BITS-1:0] scale_sample(
        input logic signed [SAMPLE_BITS-1:0] sample,
        input logic [GAIN_BITS-1:0]          gain,
        input logic [LEVEL_BITS-1:0]         level
    );
        longint prod;
        longint top_val;
        prod    = longint'(sample) * longint'(gain) * longint'(level);
        prod    = prod >>> SCALE_SHIFT;
        top_val = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        if (prod > top_val) prod = top_val;
        if (prod < -top_val - 1) prod = -top_val - 1;
        return SAMPLE_BITS'(prod);
    endfunction

    // advance the envelope by one request and build the expected result
    function automatic t_out_item advance_envelope(input t_in_item req);
        t_out_item res;
        int        lvl;
        lvl = int'(env_level);
        case (env_phase)
            PH_OFF: begin
                if (req.gate) env_phase = PH_ATTACK;
            end
            PH_ATTACK: begin
                lvl = lvl + int'(attack_step);
                if (lvl > int'(LEVEL_ONE)) begin
                    lvl       = int'(LEVEL_ONE);
                    env_phase = PH_HOLD;
                end
            end
            PH_HOLD: begin
                if (!req.gate) env_phase = PH_RELEASE;
            end
            default: begin
                lvl = lvl - int'(release_step);
                if (lvl < 0) begin
                    lvl       = 0;
                    env_phase = PH_OFF;
                end
            end
        endcase
        env_level        = LEVEL_BITS'(lvl);
        res.result_left  = scale_sample(req.sample_left, gain_left, env_level);
        res.result_right = scale_sample(req.sample_right, gain_right, env_level);
        res.level_now    = env_level;
        res.phase_now    = env_phase;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            env_phase    = PH_OFF;
            env_level    = LEVEL_ZERO;
            attack_step  = ATTACK_STEP_RST;
            release_step = RELEASE_STEP_RST;
            gain_left    = GAIN_RST;
            gain_right   = GAIN_RST;
            expected_results.delete();
        end else begin
            // register writes; unknown indexes leave everything as is
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ATTACK_STEP:  attack_step  = i_cfg_data[STEP_BITS-1:0];
                    CFG_RELEASE_STEP: release_step = i_cfg_data[STEP_BITS-1:0];
                    CFG_GAIN_LEFT:    gain_left    = i_cfg_data[GAIN_BITS-1:0];
                    CFG_GAIN_RIGHT:   gain_right   = i_cfg_data[GAIN_BITS-1:0];
                    default: ;
                endcase
            end

            // results are checked before this edge's request is predicted
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request pending, level_now", 0,
                                    i_out_data.level_now);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.result_left !== want.result_left)
                        report_mismatch("result_left", want.result_left,
                                        i_out_data.result_left);
                    if (i_out_data.result_right !== want.result_right)
                        report_mismatch("result_right", want.result_right,
                                        i_out_data.result_right);
                    if (i_out_data.level_now !== want.level_now)
                        report_mismatch("level_now", want.level_now, i_out_data.level_now);
                    if (i_out_data.phase_now !== want.phase_now)
                        report_mismatch("phase_now", want.phase_now, i_out_data.phase_now);
                end
            end

            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(advance_envelope(i_in_data));
            end
        end
        pending_results <= expected_results.size();
    end

endmodule

// ===== sim/attack_release_envelope_amp_core_tb.sv =====
// ----------------------------------------------------------------------------
// attack_release_envelope_amp_core_tb
// Drives gated stereo requests and register writes into the envelope
// amplifier under random sender gaps and receiver stalls; a checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module attack_release_envelope_amp_core_tb;
    import arenv_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RESULT_DELAY = 4;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_REQS   = 80;
    localparam int STEP_MAX     = (1 << STEP_BITS) - 1;
    localparam int GAIN_MAX     = (1 << GAIN_BITS) - 1;
    localparam int DATA_MAX     = (1 << CFG_DATA_BITS) - 1;
    localparam int SAMPLE_MAX   = (1 << (SAMPLE_BITS - 1)) - 1;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    t_in_item                 in_data   = '0;
    logic                     out_ready = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;
    logic      cfg_ready;
    int        fail_count;
    int        outstanding;

    int burst_left = 0;
    int cycle_count = 0;
    int ready_mode = 0;
    int ready_span = 0;

    attack_release_envelope_amp_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    arenv_amp_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[attack_release_envelope_amp_core] ERROR");
            $finish;
        end
    end

    // receiver: switches between always ready, coin flips, a fixed
    // one-in-four pattern and long stalls
    always @(posedge clk) begin
        if (ready_span == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_span <= $urandom_range(32, 200);
        end else begin
            ready_span <= ready_span - 1;
        end
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (cycle_count % 4 == 0);
            default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic t_in_item make_req(input logic gate, input int left, input int right);
        t_in_item req;
        req.gate         = gate;
        req.sample_left  = SAMPLE_BITS'(left);
        req.sample_right = SAMPLE_BITS'(right);
        return req;
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(0, 15))
            0:       return SAMPLE_MAX;
            1:       return -SAMPLE_MAX - 1;
            2:       return 0;
            3:       return -1;
            default: return $urandom_range(0, (1 << SAMPLE_BITS) - 1);
        endcase
    endfunction

    function automatic int pick_step();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 1;
            2:       return int'(LEVEL_ONE);
            3:       return STEP_MAX;
            4:       return $urandom_range(0, DATA_MAX);
            default: return $urandom_range(1024, 16384);
        endcase
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return GAIN_MAX;
            2:       return int'(GAIN_RST);
            3:       return $urandom_range(0, DATA_MAX);
            default: return $urandom_range(1024, 12288);
        endcase
    endfunction

    // sender: bursts of requests with random gaps between them
    task automatic send_request(input t_in_item req);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        burst_left--;
    endtask

    // stop sending and wait until every result is back
    task automatic drain_requests();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // valid stays up across back-to-back writes, dropped after the last one
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        do @(posedge clk); while (!cfg_ready);
        if (last) cfg_valid <= 1'b0;
    endtask

    // random register setting, then a stretch of note on / note off sequences
    task automatic run_random_phase(input int count);
        logic [CFG_IDX_BITS-1:0] idx_list[$];
        int                      val_list[$];
        logic                    gate_on;
        int                      gate_left;
        logic                    gate;
        if ($urandom_range(0, 3) != 0) begin
            idx_list.push_back(CFG_ATTACK_STEP);
            val_list.push_back(pick_step());
        end
        if ($urandom_range(0, 3) != 0) begin
            idx_list.push_back(CFG_RELEASE_STEP);
            val_list.push_back(pick_step());
        end
        if ($urandom_range(0, 3) != 0) begin
            idx_list.push_back(CFG_GAIN_LEFT);
            val_list.push_back(pick_gain());
        end
        if ($urandom_range(0, 3) != 0) begin
            idx_list.push_back(CFG_GAIN_RIGHT);
            val_list.push_back(pick_gain());
        end
        if ($urandom_range(0, 3) == 0) begin
            idx_list.push_back(CFG_IDX_BITS'($urandom_range(int'(CFG_GAIN_RIGHT) + 1,
                                                            (1 << CFG_IDX_BITS) - 1)));
            val_list.push_back($urandom_range(0, DATA_MAX));
        end
        foreach (idx_list[k]) write_reg(idx_list[k], val_list[k], k == idx_list.size() - 1);

        gate_on   = 1'b0;
        gate_left = $urandom_range(1, 10);
        for (int n = 0; n < count; n++) begin
            if (gate_left == 0) begin
                gate_on   = !gate_on;
                gate_left = gate_on ? $urandom_range(3, 60) : $urandom_range(2, 30);
            end
            gate_left--;
            // occasional glitch on the gate
            gate = ($urandom_range(0, 15) == 0) ? !gate_on : gate_on;
            send_request(make_req(gate, pick_sample(), pick_sample()));
        end
        drain_requests();
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values: off stays off, gate starts attack, first step
        send_request(make_req(1'b0, SAMPLE_MAX, -SAMPLE_MAX - 1));
        send_request(make_req(1'b1, SAMPLE_MAX, -SAMPLE_MAX - 1));
        send_request(make_req(1'b1, SAMPLE_MAX, -SAMPLE_MAX - 1));
        drain_requests();

        // oversized attack clamps into hold; full gains saturate; release
        // landing exactly on zero stays in release, the next step goes off
        write_reg(CFG_ATTACK_STEP, STEP_MAX, 1'b0);
        write_reg(CFG_RELEASE_STEP, int'(LEVEL_ONE), 1'b0);
        write_reg(CFG_GAIN_LEFT, GAIN_MAX, 1'b0);
        write_reg(CFG_GAIN_RIGHT, GAIN_MAX, 1'b1);
        send_request(make_req(1'b1, SAMPLE_MAX, -SAMPLE_MAX - 1));
        send_request(make_req(1'b1, -SAMPLE_MAX - 1, SAMPLE_MAX));
        send_request(make_req(1'b0, 1, -1));
        send_request(make_req(1'b1, SAMPLE_MAX, SAMPLE_MAX));
        send_request(make_req(1'b0, 0, 0));
        send_request(make_req(1'b0, -SAMPLE_MAX - 1, -SAMPLE_MAX - 1));
        drain_requests();

        // attack landing exactly on one stays in attack; zero release sticks
        write_reg(CFG_ATTACK_STEP, int'(LEVEL_ONE), 1'b0);
        write_reg(CFG_RELEASE_STEP, 0, 1'b0);
        write_reg(CFG_GAIN_LEFT, 0, 1'b0);
        write_reg(CFG_GAIN_RIGHT, int'(GAIN_RST), 1'b1);
        send_request(make_req(1'b1, SAMPLE_MAX, SAMPLE_MAX));
        send_request(make_req(1'b0, SAMPLE_MAX, -SAMPLE_MAX - 1));
        send_request(make_req(1'b0, SAMPLE_MAX, -SAMPLE_MAX - 1));
        send_request(make_req(1'b0, -1, -1));
        send_request(make_req(1'b1, 12345, -12345));
        send_request(make_req(1'b0, 1, SAMPLE_MAX));
        drain_requests();

        // big release drops to off; zero attack sticks at level zero;
        // unknown index is ignored; a step of one shows floor rounding
        write_reg(CFG_RELEASE_STEP, STEP_MAX, 1'b0);
        write_reg(CFG_ATTACK_STEP, 0, 1'b0);
        write_reg(CFG_IDX_BITS'((1 << CFG_IDX_BITS) - 1), DATA_MAX, 1'b0);
        write_reg(CFG_GAIN_LEFT, int'(GAIN_RST), 1'b1);
        send_request(make_req(1'b1, SAMPLE_MAX, SAMPLE_MAX));
        send_request(make_req(1'b1, SAMPLE_MAX, SAMPLE_MAX));
        send_request(make_req(1'b0, -1, 1));
        drain_requests();
        write_reg(CFG_ATTACK_STEP, 1, 1'b1);
        send_request(make_req(1'b1, -1, 1));
        send_request(make_req(1'b0, -SAMPLE_MAX - 1, SAMPLE_MAX));
        drain_requests();

        for (int p = 0; p < PHASE_COUNT; p++) run_random_phase(PHASE_REQS);

        repeat (2 * RESULT_DELAY) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[attack_release_envelope_amp_core] OK");
        end else begin
            $display("[attack_release_envelope_amp_core] ERROR");
        end
        $finish;
    end

endmodule
